// ----- hdl/tks_pkg.sv -----
// ----------------------------------------------------------------------------
// tks_pkg
// Shared types and constants for the top-k score sorter.
// ----------------------------------------------------------------------------
package tks_pkg;

    localparam int SCORE_W     = 32;
    localparam int DOC_W       = 16;
    localparam int RANK_W      = 7;
    localparam int DEPTH_DEF   = 64;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 56;

    typedef struct packed {
        logic                      valid;
        logic signed [SCORE_W-1:0] score;
        logic        [DOC_W-1:0]   doc;
    } t_entry;

    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctrl;

endpackage

// ----- hdl/tks_cell.sv -----
// ----------------------------------------------------------------------------
// tks_cell
// One slot of the insertion chain: holds a pair, compares it to the incoming
// pair, and shifts down on insert or up on drain.
// ----------------------------------------------------------------------------
module tks_cell
    import tks_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_entry     i_new,
    input  t_entry     i_prev,
    input  logic       i_prev_gt,
    input  t_entry     i_next,
    output t_entry     o_entry,
    output logic       o_gt
);

    logic                      r_valid;
    logic signed [SCORE_W-1:0] r_score;
    logic        [DOC_W-1:0]   r_doc;
    t_entry                    n_entry;

    // new pair belongs above this slot (ties stay below)
    assign o_gt = !r_valid || (i_new.score > r_score);

    always_comb begin
        n_entry = '{valid: r_valid, score: r_score, doc: r_doc};
        if (i_ctrl.pop) begin
            n_entry = i_next;
        end else if (i_ctrl.ins) begin
            if (i_prev_gt) begin
                n_entry = i_prev;
            end else if (o_gt) begin
                n_entry = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
        r_score <= n_entry.score;
        r_doc   <= n_entry.doc;
    end

    assign o_entry = '{valid: r_valid, score: r_score, doc: r_doc};

endmodule

// ----- hdl/top_k_score_sorter_core.sv -----
// ----------------------------------------------------------------------------
// top_k_score_sorter_core
// Stable descending top-k sorter built as a chain of insertion cells.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one request per (score, doc id) pair; tdata holds
//   the Q16.16 score in [31:0] and the doc id in [47:32], tlast marks the
//   final pair of a set. Each accepted pair is placed straight into the cell
//   chain, so pairs stream in at one per cycle except while the chain drains.
//   On the request with tlast the pair is inserted and the chain then drains
//   through a registered master stage, cell 0 first: one result per cycle
//   while the receiver takes them, ranks counting from 1, tlast on the last.
//   The tlast request sets the drain state, which then loads the output
//   register. Input is held off (tready low) while the chain drains; the
//   final result may still wait in the output register while new pairs are
//   already taken. A stalled receiver freezes the drain; nothing is lost.
//   Reset clears every cell's valid flag and the drain state; the block is
//   ready as soon as reset is released. Sets of more than DEPTH pairs keep
//   the DEPTH highest, later equal scores being dropped.
// ----------------------------------------------------------------------------
module top_k_score_sorter_core
    import tks_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // score[31:0], doc_id[47:32]
    input  logic                 i_s_tlast,  // last
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,  // ranked_score[31:0], ranked_doc[47:32],
                                             // rank[54:48], zero[55]
    output logic                 o_m_tlast   // final_res
);

    typedef enum logic {ST_FILL, ST_DRAIN} t_state;

    t_state              r_state;
    logic                r_out_valid;
    logic                r_out_last;
    logic [SCORE_W-1:0]  r_out_score;
    logic [DOC_W-1:0]    r_out_doc;
    logic [RANK_W-1:0]   r_out_rank;
    logic [RANK_W-1:0]   r_rank;

    t_entry              w_new;
    t_entry              w_entry [DEPTH];
    logic                w_gt    [DEPTH];
    logic [DEPTH-1:0]    w_valid;
    t_cell_ctrl          w_ctrl;
    logic                w_in_acc;
    logic                w_load;

    assign o_s_tready = (r_state == ST_FILL);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_load     = (r_state == ST_DRAIN) && (!r_out_valid || i_m_tready);

    assign w_new  = '{valid: 1'b1, score: i_s_tdata[SCORE_W-1:0],
                      doc: i_s_tdata[SCORE_W+DOC_W-1:SCORE_W]};
    assign w_ctrl = '{ins: w_in_acc, pop: w_load};

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        t_entry w_prev;
        t_entry w_next;
        logic   w_prev_gt;

        if (i == 0) begin : g_head
            assign w_prev    = '0;
            assign w_prev_gt = 1'b0;
        end else begin : g_body
            assign w_prev    = w_entry[i-1];
            assign w_prev_gt = w_gt[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_entry[i+1];
        end

        tks_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (w_ctrl),
            .i_new     (w_new),
            .i_prev    (w_prev),
            .i_prev_gt (w_prev_gt),
            .i_next    (w_next),
            .o_entry   (w_entry[i]),
            .o_gt      (w_gt[i])
        );

        assign w_valid[i] = w_entry[i].valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
            r_rank      <= RANK_W'(1);
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_out_last  <= !w_valid[1];
            end else if (o_m_tvalid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_FILL: begin
                    if (w_in_acc && i_s_tlast) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (w_load) begin
                        if (!w_valid[1]) begin
                            r_rank  <= RANK_W'(1);
                            r_state <= ST_FILL;
                        end else begin
                            r_rank  <= r_rank + RANK_W'(1);
                        end
                    end
                end
                default: r_state <= ST_FILL;
            endcase
        end
        if (w_load) begin
            r_out_rank  <= r_rank;
            r_out_score <= w_entry[0].score;
            r_out_doc   <= w_entry[0].doc;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {1'b0, r_out_rank, r_out_doc, r_out_score};

    // occupied cells stay packed toward cell 0
    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid >> 1) & ~w_valid) == '0)
        else $error("cell chain has a hole");

    // a drain never starts on an empty chain
    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> w_valid[0])
        else $error("drain with empty chain");

    // the result after a final one restarts at rank 1
    a_rank_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !w_valid[1]) |=> (r_rank == RANK_W'(1)) && (r_state == ST_FILL))
        else $error("rank not restarted after final result");

endmodule
